// ===== src/assert_macros.svh =====
// Concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/pnrf_pkg.sv =====
package pnrf_pkg;

    localparam int VAL_W      = 48;
    localparam int FRAC_BITS  = 24;
    localparam int HALF_W     = VAL_W / 2;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int DVD_W      = VAL_W + 1 + FRAC_BITS;
    localparam int NUM_COEF   = 6;

    localparam logic [VAL_W-1:0] STEP_FIXED = 48'd16777;
    localparam logic [VAL_W-1:0] VAL_MAX    = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN    = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [2:0]       MAX_DEGREE = 3'd5;
    localparam logic [6:0]       MAX_ITER   = 7'd64;
    localparam logic [6:0]       DIV_LAST   = 7'(DVD_W - 1);

    localparam logic [2:0] REG_DEGREE = 3'd0;
    localparam logic [2:0] REG_LIMIT  = 3'd1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_INIT  = 9'b000000010,
        S_MUL   = 9'b000000100,
        S_RND   = 9'b000001000,
        S_ADD   = 9'b000010000,
        S_EDONE = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_POST  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic             sat;
    } t_sat;

    function automatic t_sat sat_from_mag(input logic [DVD_W-1:0] mag, input logic neg);
        t_sat             r;
        logic [DVD_W-1:0] lim;
        lim = neg ? DVD_W'({1'b1, {(VAL_W-1){1'b0}}}) : DVD_W'(VAL_MAX);
        if (mag > lim) begin
            r.sat = 1'b1;
            r.val = neg ? VAL_MIN : VAL_MAX;
        end else begin
            r.sat = 1'b0;
            r.val = neg ? (~mag[VAL_W-1:0] + 1'b1) : mag[VAL_W-1:0];
        end
        return r;
    endfunction

    function automatic t_sat clamp49(input logic [VAL_W:0] v);
        t_sat r;
        if (v[VAL_W] != v[VAL_W-1]) begin
            r.sat = 1'b1;
            r.val = v[VAL_W] ? VAL_MIN : VAL_MAX;
        end else begin
            r.sat = 1'b0;
            r.val = v[VAL_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] mag48(input logic [VAL_W-1:0] v);
        return v[VAL_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// ===== src/polynomial_newton_root_finder_top.sv =====
// Each iteration is computed on a shared 24x24 multiplier (partial products accumulated,
// then round and add) and a 73-step restoring divider; a zero-slope iteration skips the
// second division. One start estimate yields up to iteration_limit (clamped to 1..64)
// result beats; a new start estimate is taken only once the run is done, and any stall
// on the result side holds the run.
// Reset (synchronous, active low) returns to idle and restores degree 0, limit 8 and zero coefficients.
`include "assert_macros.svh"

module polynomial_newton_root_finder_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [pnrf_pkg::VAL_W-1:0]    i_start_estimate,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [5:0]                    o_iteration_index,
    output logic [pnrf_pkg::VAL_W-1:0]    o_poly_value,
    output logic [pnrf_pkg::VAL_W-1:0]    o_slope,
    output logic [pnrf_pkg::VAL_W-1:0]    o_correction,
    output logic [pnrf_pkg::VAL_W-1:0]    o_new_estimate,
    output logic                          o_slope_zero,
    output logic                          o_saturated,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [5:0]                    paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);
    import pnrf_pkg::*;

    t_state             r_state, n_state;
    logic [2:0]         r_degree;
    logic [6:0]         r_limit;
    logic [VAL_W-1:0]   r_coef [NUM_COEF];

    logic [VAL_W-1:0]   r_x, n_x, r_xe, n_xe, r_acc, n_acc, r_p0, n_p0;
    logic [VAL_W-1:0]   r_slope, n_slope, r_corr, n_corr, r_nx, n_nx;
    logic [2:0]         r_k, n_k;
    logic [1:0]         r_mcnt, n_mcnt;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic               r_pass, n_pass, r_dphase, n_dphase;
    logic               r_sat, n_sat, r_zero, n_zero;
    logic [5:0]         r_iter, n_iter;
    logic [DVD_W-1:0]   r_dvd, n_dvd, r_quo, n_quo;
    logic [VAL_W-1:0]   r_rem, n_rem, r_den, n_den;
    logic [6:0]         r_dcnt, n_dcnt;
    logic               r_dneg, n_dneg;

    logic [2:0]         deg_eff;
    logic [6:0]         lim_eff;
    logic               cfg_wr, out_beat, last;
    logic [VAL_W-1:0]   a_mag, b_mag;
    logic [HALF_W-1:0]  a_sel, b_sel;
    logic [VAL_W-1:0]   pp;
    logic [PROD_W-1:0]  pp_sh, rnd;
    logic [VAL_W:0]     rem_sh, diff;
    t_sat               mul_res, add_res, xh_res, q_res, nx_res;

    assign deg_eff = (r_degree > MAX_DEGREE) ? MAX_DEGREE : r_degree;
    assign lim_eff = (r_limit == 7'd0) ? 7'd1 : ((r_limit > MAX_ITER) ? MAX_ITER : r_limit);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = (r_state == S_OUT);
    assign out_beat = o_valid && i_ready;
    assign last     = r_zero || (({1'b0, r_iter} + 7'd1) == lim_eff);

    assign o_iteration_index = r_iter;
    assign o_poly_value      = r_p0;
    assign o_slope           = r_slope;
    assign o_correction      = r_corr;
    assign o_new_estimate    = r_nx;
    assign o_slope_zero      = r_zero;
    assign o_saturated       = r_sat;
    assign o_last            = last;

    always_comb begin
        case (paddr[5:3])
            REG_DEGREE: prdata = {61'd0, r_degree};
            REG_LIMIT:  prdata = {57'd0, r_limit};
            default:    prdata = {{(64-VAL_W){r_coef[paddr[5:3] - 3'd2][VAL_W-1]}},
                                  r_coef[paddr[5:3] - 3'd2]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= 3'd0;
            r_limit  <= 7'd8;
            for (int i = 0; i < NUM_COEF; i++) r_coef[i] <= '0;
        end else if (cfg_wr) begin
            case (paddr[5:3])
                REG_DEGREE: r_degree <= pwdata[2:0];
                REG_LIMIT:  r_limit  <= pwdata[6:0];
                default:    r_coef[paddr[5:3] - 3'd2] <= pwdata[VAL_W-1:0];
            endcase
        end
    end

    assign a_mag = mag48(r_acc);
    assign b_mag = mag48(r_xe);
    assign a_sel = r_mcnt[0] ? a_mag[VAL_W-1:HALF_W] : a_mag[HALF_W-1:0];
    assign b_sel = r_mcnt[1] ? b_mag[VAL_W-1:HALF_W] : b_mag[HALF_W-1:0];
    assign pp    = {{HALF_W{1'b0}}, a_sel} * {{HALF_W{1'b0}}, b_sel};

    always_comb begin
        case (r_mcnt)
            2'd0:    pp_sh = {{VAL_W{1'b0}}, pp};
            2'd3:    pp_sh = {pp, {VAL_W{1'b0}}};
            default: pp_sh = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
        endcase
    end

    assign rnd     = r_prod + (PROD_W'(1) << (FRAC_BITS - 1));
    assign mul_res = sat_from_mag(DVD_W'(rnd[PROD_W-1:FRAC_BITS]), r_acc[VAL_W-1] ^ r_xe[VAL_W-1]);
    assign add_res = clamp49({r_acc[VAL_W-1], r_acc} +
                             {r_coef[r_k - 3'd1][VAL_W-1], r_coef[r_k - 3'd1]});
    assign xh_res  = clamp49({r_x[VAL_W-1], r_x} + {1'b0, STEP_FIXED});
    assign diff    = {r_acc[VAL_W-1], r_acc} - {r_p0[VAL_W-1], r_p0};
    assign rem_sh  = {r_rem, r_dvd[DVD_W-1]};
    assign q_res   = sat_from_mag(r_quo, r_dneg);
    assign nx_res  = clamp49({r_x[VAL_W-1], r_x} - {q_res.val[VAL_W-1], q_res.val});

    always_comb begin
        n_state  = r_state;
        n_x      = r_x;
        n_xe     = r_xe;
        n_acc    = r_acc;
        n_p0     = r_p0;
        n_slope  = r_slope;
        n_corr   = r_corr;
        n_nx     = r_nx;
        n_k      = r_k;
        n_mcnt   = r_mcnt;
        n_prod   = r_prod;
        n_pass   = r_pass;
        n_dphase = r_dphase;
        n_sat    = r_sat;
        n_zero   = r_zero;
        n_iter   = r_iter;
        n_dvd    = r_dvd;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_den    = r_den;
        n_dcnt   = r_dcnt;
        n_dneg   = r_dneg;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_x     = i_start_estimate;
                    n_xe    = i_start_estimate;
                    n_iter  = 6'd0;
                    n_pass  = 1'b0;
                    n_sat   = 1'b0;
                    n_zero  = 1'b0;
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_acc   = r_coef[deg_eff];
                n_k     = deg_eff;
                n_mcnt  = 2'd0;
                n_prod  = '0;
                n_state = (deg_eff == 3'd0) ? S_EDONE : S_MUL;
            end
            S_MUL: begin
                n_prod = r_prod + pp_sh;
                n_mcnt = r_mcnt + 2'd1;
                if (r_mcnt == 2'd3) n_state = S_RND;
            end
            S_RND: begin
                n_acc   = mul_res.val;
                n_sat   = r_sat | mul_res.sat;
                n_state = S_ADD;
            end
            S_ADD: begin
                n_acc   = add_res.val;
                n_sat   = r_sat | add_res.sat;
                n_k     = r_k - 3'd1;
                n_mcnt  = 2'd0;
                n_prod  = '0;
                n_state = (r_k == 3'd1) ? S_EDONE : S_MUL;
            end
            S_EDONE: begin
                if (!r_pass) begin
                    n_p0    = r_acc;
                    n_xe    = xh_res.val;
                    n_sat   = r_sat | xh_res.sat;
                    n_pass  = 1'b1;
                    n_state = S_INIT;
                end else begin
                    n_dvd    = {(diff[VAL_W] ? (~diff + 1'b1) : diff), {FRAC_BITS{1'b0}}};
                    n_dneg   = diff[VAL_W];
                    n_den    = STEP_FIXED;
                    n_rem    = '0;
                    n_quo    = '0;
                    n_dcnt   = 7'd0;
                    n_dphase = 1'b0;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                n_dvd  = {r_dvd[DVD_W-2:0], 1'b0};
                if (rem_sh >= {1'b0, r_den}) begin
                    n_rem = VAL_W'(rem_sh - {1'b0, r_den});
                    n_quo = {r_quo[DVD_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[VAL_W-1:0];
                    n_quo = {r_quo[DVD_W-2:0], 1'b0};
                end
                n_dcnt = r_dcnt + 7'd1;
                if (r_dcnt == DIV_LAST) n_state = S_POST;
            end
            S_POST: begin
                n_sat = r_sat | q_res.sat;
                if (!r_dphase) begin
                    n_slope = q_res.val;
                    if (q_res.val == '0) begin
                        n_zero  = 1'b1;
                        n_corr  = '0;
                        n_nx    = r_x;
                        n_state = S_OUT;
                    end else begin
                        n_dvd    = {1'b0, mag48(r_p0), {FRAC_BITS{1'b0}}};
                        n_dneg   = r_p0[VAL_W-1] ^ q_res.val[VAL_W-1];
                        n_den    = mag48(q_res.val);
                        n_rem    = '0;
                        n_quo    = '0;
                        n_dcnt   = 7'd0;
                        n_dphase = 1'b1;
                        n_state  = S_DIV;
                    end
                end else begin
                    n_corr  = q_res.val;
                    n_nx    = nx_res.val;
                    n_sat   = r_sat | q_res.sat | nx_res.sat;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    if (last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_x     = r_nx;
                        n_xe    = r_nx;
                        n_iter  = r_iter + 6'd1;
                        n_pass  = 1'b0;
                        n_sat   = 1'b0;
                        n_state = S_INIT;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_x      <= n_x;
        r_xe     <= n_xe;
        r_acc    <= n_acc;
        r_p0     <= n_p0;
        r_slope  <= n_slope;
        r_corr   <= n_corr;
        r_nx     <= n_nx;
        r_k      <= n_k;
        r_mcnt   <= n_mcnt;
        r_prod   <= n_prod;
        r_pass   <= n_pass;
        r_dphase <= n_dphase;
        r_sat    <= n_sat;
        r_zero   <= n_zero;
        r_iter   <= n_iter;
        r_dvd    <= n_dvd;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_dcnt   <= n_dcnt;
        r_dneg   <= n_dneg;
    end

    `ASSERT_ALWAYS(a_no_overlap, i_clk, i_rst_n, !(o_valid && o_ready))
    `ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `ASSERT_IMPLY(a_zero_ends, i_clk, i_rst_n, o_valid && o_slope_zero, o_last && (o_correction == '0) && (o_slope == '0))
    `ASSERT_NEXT(a_last_idles, i_clk, i_rst_n, out_beat && o_last, o_ready)

endmodule
